FILE: rtl/tcp_option_parser_assert.svh
`ifndef TCP_OPTION_PARSER_ASSERT_SVH
`define TCP_OPTION_PARSER_ASSERT_SVH

// same-cycle implication, checked at every rising edge of clk unless rst is high
`define TCPOP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcpop assertion failed");

// next-cycle implication
`define TCPOP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpop assertion failed");

`endif

FILE: rtl/tcpop_pkg.sv
package tcpop_pkg;

   // largest option area, counts above it are clamped
   localparam logic [7:0] AREA_MAX = 8'd40;

   // queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // option kind bytes
   localparam logic [7:0] KIND_END   = 8'd0;
   localparam logic [7:0] KIND_NOP   = 8'd1;
   localparam logic [7:0] KIND_MSS   = 8'd2;
   localparam logic [7:0] KIND_WS    = 8'd3;
   localparam logic [7:0] KIND_SACKP = 8'd4;
   localparam logic [7:0] KIND_SACK  = 8'd5;
   localparam logic [7:0] KIND_TS    = 8'd8;

   // fixed option lengths
   localparam logic [7:0] LEN_MSS   = 8'd4;
   localparam logic [7:0] LEN_WS    = 8'd3;
   localparam logic [7:0] LEN_SACKP = 8'd2;
   localparam logic [7:0] LEN_TS    = 8'd10;
   localparam logic [7:0] LEN_MIN   = 8'd2;

   // result kinds
   localparam logic [2:0] RK_NOP      = 3'd0;
   localparam logic [2:0] RK_MSS      = 3'd1;
   localparam logic [2:0] RK_WSCALE   = 3'd2;
   localparam logic [2:0] RK_SACKPERM = 3'd3;
   localparam logic [2:0] RK_SACK     = 3'd4;
   localparam logic [2:0] RK_TS       = 3'd5;
   localparam logic [2:0] RK_UNKNOWN  = 3'd6;
   localparam logic [2:0] RK_SUMMARY  = 3'd7;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_TRUNC  = 2'd1;
   localparam logic [1:0] ST_BADLEN = 2'd2;

   typedef struct packed {
      logic [7:0] opt_byte;
      logic [5:0] bytes_left;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [7:0]  option_code;
      logic [7:0]  length_byte;
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [1:0]  status;
      logic        done_res;
   } rsp_type;

   // up to two results caused by one byte
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } entry_type;

endpackage

FILE: rtl/tcp_option_parser.sv
// tcp option area parser: takes the option area of a tcp header one byte per beat, each
// byte tagged with the count of bytes left in the area (1 on the last byte, 0 read as 1,
// counts above 40 read as 40), and returns one result beat per option found: nop, mss,
// window scale shift, sack permitted, one beat per sack block, the timestamp pair, or an
// unknown kind with its length byte. end of list takes a byte and returns nothing. the
// first truncated or badly sized option returns an error beat with done_res set and the
// rest of that area is skipped; a clean area closes with a summary beat, or, where its
// last byte already gives two results, with done_res set on the second. input rate is one
// byte per cycle while req_ready is high; each result passes through the result queue and
// the output register before it shows on rsp, and the result port moves one beat per cycle
// while rsp_ready is high. req_ready drops only while the four-entry result queue is full,
// i.e. while results come in faster than rsp takes them. no clearing pass after reset.
module tcp_option_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcpop_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcpop_pkg::rsp_type rsp_data
);
   import tcpop_pkg::*;

   // front to queue
   logic      push;
   entry_type push_entry;

   // queue to back
   logic      pop;
   entry_type pop_entry;
   logic      q_full;
   logic      q_empty;

   // bytes are taken whenever the queue has a free slot
   assign req_ready = !q_full;

   // front: per-byte option walk, builds up to two results per byte
   tcpop_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_entry (push_entry)
   );

   // short queue so the walk never waits on a single stalled beat
   tcpop_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   // back: splits each entry into single result beats behind an output register
   tcpop_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/tcpop_front.sv
module tcpop_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  tcpop_pkg::req_type  req_data,
   output logic                push,
   output tcpop_pkg::entry_type push_entry
);
   import tcpop_pkg::*;

   typedef enum logic [1:0] {PH_KIND, PH_LEN, PH_BODY} phase_type;

   phase_type   phase_ff, phase_in;
   logic        stop_ff, stop_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  idx_ff, idx_in;
   logic [31:0] wa_ff, wa_in;
   logic [31:0] wb_ff, wb_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  n8;
   logic [8:0]  n_plus1;
   logic [8:0]  b9;
   logic [8:0]  idx_plus1;
   logic [31:0] sa, sb;
   logic [2:0]  sack_off;
   logic        m0_v, m1_v, e_v;
   rsp_type     m0, m1, e;

   function automatic logic [2:0] kind_class(input logic [7:0] k);
      logic [2:0] c;
      unique case (k)
         KIND_MSS:   c = RK_MSS;
         KIND_WS:    c = RK_WSCALE;
         KIND_SACKP: c = RK_SACKPERM;
         KIND_SACK:  c = RK_SACK;
         KIND_TS:    c = RK_TS;
         default:    c = RK_UNKNOWN;
      endcase
      return c;
   endfunction

   // bytes an option needs from its kind byte on
   function automatic logic [7:0] need_len(input logic [7:0] k);
      logic [7:0] l;
      unique case (k)
         KIND_MSS: l = LEN_MSS;
         KIND_WS:  l = LEN_WS;
         KIND_TS:  l = LEN_TS;
         default:  l = LEN_MIN;
      endcase
      return l;
   endfunction

   function automatic logic [7:0] want_len(input logic [7:0] k);
      logic [7:0] l;
      unique case (k)
         KIND_MSS:   l = LEN_MSS;
         KIND_WS:    l = LEN_WS;
         KIND_SACKP: l = LEN_SACKP;
         default:    l = LEN_TS;
      endcase
      return l;
   endfunction

   function automatic rsp_type build_rsp(input logic [2:0] rk, input logic [7:0] code,
                                         input logic [7:0] len, input logic [31:0] a,
                                         input logic [31:0] bv, input logic [1:0] st,
                                         input logic dn);
      rsp_type r;
      r.result_kind = rk;
      r.option_code = code;
      r.length_byte = len;
      r.value_a     = a;
      r.value_b     = bv;
      r.status      = st;
      r.done_res    = dn;
      return r;
   endfunction

   assign accept    = req_valid & req_ready;
   assign b         = req_data.opt_byte;
   assign n8        = (req_data.bytes_left == 6'd0) ? 8'd1 :
                      ({2'b00, req_data.bytes_left} > AREA_MAX) ? AREA_MAX :
                      {2'b00, req_data.bytes_left};
   assign n_plus1   = {1'b0, n8} + 9'd1;
   assign b9        = {1'b0, b};
   assign idx_plus1 = {1'b0, idx_ff} + 9'd1;
   assign sa        = {wa_ff[23:0], b};
   assign sb        = {wb_ff[23:0], b};
   assign sack_off  = idx_ff[2:0] - 3'd2;

   always_comb begin
      phase_in = phase_ff;
      stop_in  = stop_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      wa_in    = wa_ff;
      wb_in    = wb_ff;
      m0_v     = 1'b0;
      m1_v     = 1'b0;
      e_v      = 1'b0;
      m0       = '0;
      m1       = '0;
      e        = '0;

      if (!stop_ff) begin
         unique case (phase_ff)
            PH_KIND: begin
               kind_in = b;
               len_in  = 8'd0;
               idx_in  = 8'd0;
               wa_in   = '0;
               wb_in   = '0;
               if (b == KIND_NOP) begin
                  m0_v = 1'b1;
                  m0   = build_rsp(RK_NOP, KIND_NOP, 8'd0, '0, '0, ST_OK, 1'b0);
               end else if (b != KIND_END) begin
                  if (n8 < need_len(b)) begin
                     m0_v    = 1'b1;
                     m0      = build_rsp(kind_class(b), b, 8'd0, '0, '0, ST_TRUNC, 1'b1);
                     stop_in = 1'b1;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               len_in   = b;
               idx_in   = 8'd2;
               phase_in = PH_BODY;
               if (kind_ff inside {KIND_MSS, KIND_WS, KIND_SACKP, KIND_TS}) begin
                  if (b != want_len(kind_ff)) begin
                     m0_v     = 1'b1;
                     m0       = build_rsp(kind_class(kind_ff), kind_ff, b, '0, '0,
                                          ST_BADLEN, 1'b1);
                     stop_in  = 1'b1;
                     phase_in = PH_KIND;
                  end else if (kind_ff == KIND_SACKP) begin
                     m0_v     = 1'b1;
                     m0       = build_rsp(RK_SACKPERM, KIND_SACKP, b, '0, '0, ST_OK, 1'b0);
                     phase_in = PH_KIND;
                  end
               end else if (kind_ff == KIND_SACK) begin
                  if (n_plus1 < b9) begin
                     m0_v     = 1'b1;
                     m0       = build_rsp(RK_SACK, kind_ff, b, '0, '0, ST_TRUNC, 1'b1);
                     stop_in  = 1'b1;
                     phase_in = PH_KIND;
                  end else if (b <= LEN_MIN || b[2:0] != 3'd2) begin
                     // block area must be a whole number of eight-byte blocks
                     m0_v     = 1'b1;
                     m0       = build_rsp(RK_SACK, kind_ff, b, '0, '0, ST_BADLEN, 1'b1);
                     stop_in  = 1'b1;
                     phase_in = PH_KIND;
                  end
               end else begin
                  if (b == 8'd0 || n_plus1 < b9) begin
                     m0_v     = 1'b1;
                     m0       = build_rsp(RK_UNKNOWN, kind_ff, b, '0, '0, ST_BADLEN, 1'b1);
                     stop_in  = 1'b1;
                     phase_in = PH_KIND;
                  end else begin
                     m0_v = 1'b1;
                     m0   = build_rsp(RK_UNKNOWN, kind_ff, b, '0, '0, ST_OK, 1'b0);
                     if (b == 8'd1) begin
                        // length byte of one doubles as a nop kind byte
                        phase_in = PH_KIND;
                        kind_in  = KIND_NOP;
                        len_in   = 8'd0;
                        idx_in   = 8'd0;
                        wa_in    = '0;
                        wb_in    = '0;
                        m1_v     = 1'b1;
                        m1       = build_rsp(RK_NOP, KIND_NOP, 8'd0, '0, '0, ST_OK, 1'b0);
                     end else if (b == LEN_MIN) begin
                        phase_in = PH_KIND;
                     end
                  end
               end
            end
            PH_BODY: begin
               idx_in = idx_plus1[7:0];
               case (kind_ff)
                  KIND_MSS: begin
                     wa_in = sa;
                     if (idx_ff >= 8'd3) begin
                        m0_v     = 1'b1;
                        m0       = build_rsp(RK_MSS, KIND_MSS, len_ff, {16'd0, sa[15:0]}, '0,
                                             ST_OK, 1'b0);
                        phase_in = PH_KIND;
                     end
                  end
                  KIND_WS: begin
                     m0_v     = 1'b1;
                     m0       = build_rsp(RK_WSCALE, KIND_WS, len_ff, {24'd0, b}, '0,
                                          ST_OK, 1'b0);
                     phase_in = PH_KIND;
                  end
                  KIND_TS: begin
                     if (idx_ff < 8'd6) begin
                        wa_in = sa;
                     end else begin
                        wb_in = sb;
                     end
                     if (idx_ff >= 8'd9) begin
                        m0_v     = 1'b1;
                        m0       = build_rsp(RK_TS, KIND_TS, len_ff, wa_ff, sb, ST_OK, 1'b0);
                        phase_in = PH_KIND;
                     end
                  end
                  KIND_SACK: begin
                     if (sack_off < 3'd4) begin
                        wa_in = sa;
                     end else begin
                        wb_in = sb;
                     end
                     if (sack_off == 3'd7) begin
                        m0_v = 1'b1;
                        m0   = build_rsp(RK_SACK, KIND_SACK, len_ff, wa_ff, sb, ST_OK, 1'b0);
                     end
                     if (idx_plus1 >= {1'b0, len_ff}) begin
                        phase_in = PH_KIND;
                     end
                  end
                  default: begin
                     if (idx_plus1 >= {1'b0, len_ff}) begin
                        phase_in = PH_KIND;
                     end
                  end
               endcase
            end
            default: phase_in = PH_KIND;
         endcase
      end

      // last byte of the area
      if (n8 == 8'd1) begin
         if (!stop_in) begin
            if (phase_in != PH_KIND) begin
               e_v = 1'b1;
               e   = build_rsp(kind_class(kind_in), kind_in, len_in, '0, '0, ST_TRUNC, 1'b1);
            end else if (!m1_v) begin
               e_v = 1'b1;
               e   = build_rsp(RK_SUMMARY, 8'd0, 8'd0, '0, '0, ST_OK, 1'b1);
            end else begin
               m1.done_res = 1'b1;
            end
         end
         stop_in  = 1'b0;
         phase_in = PH_KIND;
         idx_in   = 8'd0;
      end
   end

   always_comb begin
      push_entry.first  = m0_v ? m0 : e;
      push_entry.second = m1_v ? m1 : e;
      push_entry.two    = m0_v & (m1_v | e_v);
      push              = accept & (m0_v | e_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KIND;
         stop_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         stop_ff  <= stop_in;
      end
      if (accept) begin
         kind_ff <= kind_in;
         len_ff  <= len_in;
         idx_ff  <= idx_in;
         wa_ff   <= wa_in;
         wb_ff   <= wb_in;
      end
   end

endmodule

FILE: rtl/tcpop_queue.sv
module tcpop_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tcpop_pkg::entry_type push_entry,
   input  logic                 pop,
   output tcpop_pkg::entry_type pop_entry,
   output logic                 full,
   output logic                 empty
);
   import tcpop_pkg::*;

   entry_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]     count_ff, count_in;

   assign full      = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/tcpop_back.sv
module tcpop_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  tcpop_pkg::entry_type pop_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tcpop_pkg::rsp_type   rsp_data
);
   import tcpop_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    sec_valid_ff, sec_valid_in;
   rsp_type sec_ff, sec_in;
   logic    out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = out_free && !sec_valid_ff && !empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      sec_valid_in = sec_valid_ff;
      sec_in       = sec_ff;
      if (out_free) begin
         if (sec_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = sec_ff;
            sec_valid_in = 1'b0;
         end else if (!empty) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pop_entry.first;
            sec_valid_in = pop_entry.two;
            sec_in       = pop_entry.second;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      sec_ff      <= sec_in;
   end

endmodule

FILE: rtl/tcpop_checker.sv
`include "tcp_option_parser_assert.svh"

module tcpop_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input tcpop_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input tcpop_pkg::rsp_type rsp_data
);
   import tcpop_pkg::*;

   logic req_wait;
   logic rsp_wait;
   logic rsp_err;
   logic rsp_sum;

   assign req_wait = req_valid && !req_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;
   assign rsp_err  = rsp_valid && rsp_data.status != ST_OK;
   assign rsp_sum  = rsp_valid && rsp_data.result_kind == RK_SUMMARY;

   // nothing left on the result port once reset has been seen
   `TCPOP_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

   // a held-off request beat stays put
   `TCPOP_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_data))

   // a held-off result beat stays put
   `TCPOP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))

   // an error always closes the area
   `TCPOP_ASSERT_IMPLY(a_err_done, clock, reset, rsp_err, rsp_data.done_res)

   // a summary beat is clean and closes the area
   `TCPOP_ASSERT_IMPLY(a_sum_done, clock, reset, rsp_sum, rsp_data.done_res && !rsp_err)

endmodule

bind tcp_option_parser tcpop_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: test/tcp_option_parser_tb.sv
`timescale 1ns / 1ps
module tcp_option_parser_tb;
   import tcpop_pkg::*;

   localparam int STALL_LIMIT  = 1000;  // cycles with no beat on either side
   localparam int RANDOM_BEATS = 1050;
   localparam int TAIL_CYCLES  = 40;    // result queue drains well within this

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   tcp_option_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ------------------------------------------------------------------
   // option walker: mirrors the parser one byte at a time
   // ------------------------------------------------------------------
   typedef enum logic [1:0] {AT_KIND, AT_LENGTH, IN_BODY} walk_phase_type;

   walk_phase_type walk_phase  = AT_KIND;
   logic [7:0]     opt_kind    = 8'd0;
   logic [7:0]     opt_len     = 8'd0;
   logic [7:0]     body_pos    = 8'd0;
   logic [31:0]    acc_a       = 32'd0;
   logic [31:0]    acc_b       = 32'd0;
   logic           area_halted = 1'b0;

   // results caused by the byte just walked, at most two
   rsp_type beat_results [0:1];
   int      beat_result_count;

   // results still owed by the parser, oldest first
   rsp_type expected_results [$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int random_sent    = 0;
   bit req_burst      = 1'b0;
   bit rsp_burst      = 1'b0;

   // directed rows: typed rows carry their results, the rest go through the walker
   typedef struct packed {
      req_type    beat;
      logic       typed;
      logic [1:0] n_typed;
      rsp_type    r0;
      rsp_type    r1;
   } stim_row_type;

   stim_row_type stim_rows [$];
   logic [7:0]   area_bytes [$];

   function automatic rsp_type pack_result(logic [2:0] kind, logic [7:0] code,
                                           logic [7:0] len, logic [31:0] a,
                                           logic [31:0] b, logic [1:0] st, logic dn);
      rsp_type r;
      r.result_kind = kind;
      r.option_code = code;
      r.length_byte = len;
      r.value_a     = a;
      r.value_b     = b;
      r.status      = st;
      r.done_res    = dn;
      return r;
   endfunction

   // a third result from one byte is simply dropped
   function automatic void note_result(rsp_type r);
      if (beat_result_count < 2) begin
         beat_results[beat_result_count] = r;
         beat_result_count++;
      end
   endfunction

   function automatic logic [2:0] result_kind_of(logic [7:0] k);
      case (k)
         KIND_MSS:   return RK_MSS;
         KIND_WS:    return RK_WSCALE;
         KIND_SACKP: return RK_SACKPERM;
         KIND_SACK:  return RK_SACK;
         KIND_TS:    return RK_TS;
         default:    return RK_UNKNOWN;
      endcase
   endfunction

   // error beat closes the area, remaining bytes are skipped
   function automatic void abort_area(logic [7:0] len, logic [1:0] st);
      note_result(pack_result(result_kind_of(opt_kind), opt_kind, len, 32'd0, 32'd0, st, 1'b1));
      area_halted = 1'b1;
      walk_phase  = AT_KIND;
   endfunction

   function automatic void take_kind(logic [7:0] b, int n);
      int need;
      opt_kind = b;
      opt_len  = 8'd0;
      body_pos = 8'd0;
      acc_a    = 32'd0;
      acc_b    = 32'd0;
      if (b == KIND_END)
         return;
      if (b == KIND_NOP) begin
         note_result(pack_result(RK_NOP, KIND_NOP, 8'd0, 32'd0, 32'd0, ST_OK, 1'b0));
         return;
      end
      case (b)
         KIND_MSS: need = LEN_MSS;
         KIND_WS:  need = LEN_WS;
         KIND_TS:  need = LEN_TS;
         default:  need = LEN_MIN;
      endcase
      // not enough bytes left for the whole option, or no length byte at all
      if (n < need) begin
         abort_area(8'd0, ST_TRUNC);
         return;
      end
      walk_phase = AT_LENGTH;
   endfunction

   function automatic void take_length(logic [7:0] len, int n);
      int want;
      opt_len    = len;
      body_pos   = 8'd2;
      walk_phase = IN_BODY;
      case (opt_kind)
         KIND_MSS, KIND_WS, KIND_SACKP, KIND_TS: begin
            case (opt_kind)
               KIND_MSS:   want = LEN_MSS;
               KIND_WS:    want = LEN_WS;
               KIND_SACKP: want = LEN_SACKP;
               default:    want = LEN_TS;
            endcase
            if (len != want)
               abort_area(len, ST_BADLEN);
            else if (opt_kind == KIND_SACKP) begin
               note_result(pack_result(RK_SACKPERM, KIND_SACKP, len, 32'd0, 32'd0, ST_OK, 1'b0));
               walk_phase = AT_KIND;
            end
         end
         KIND_SACK: begin
            // truncation is checked ahead of the block-size rule
            if (n + 1 < len)
               abort_area(len, ST_TRUNC);
            else if (len <= 2 || ((len - 8'd2) & 8'd7) != 8'd0)
               abort_area(len, ST_BADLEN);
         end
         default: begin
            if (len == 0 || n + 1 < len)
               abort_area(len, ST_BADLEN);
            else begin
               note_result(pack_result(RK_UNKNOWN, opt_kind, len, 32'd0, 32'd0, ST_OK, 1'b0));
               // length 1 is read again as the next kind, which is a nop
               if (len == 1) begin
                  walk_phase = AT_KIND;
                  take_kind(len, n);
               end else if (len == 2)
                  walk_phase = AT_KIND;
            end
         end
      endcase
   endfunction

   function automatic void take_body(logic [7:0] b);
      int i;
      int off;
      i = body_pos;
      case (opt_kind)
         KIND_MSS: begin
            acc_a = {acc_a[23:0], b};
            if (i >= 3) begin
               note_result(pack_result(RK_MSS, KIND_MSS, opt_len, {16'd0, acc_a[15:0]},
                                       32'd0, ST_OK, 1'b0));
               walk_phase = AT_KIND;
            end
         end
         KIND_WS: begin
            note_result(pack_result(RK_WSCALE, KIND_WS, opt_len, {24'd0, b}, 32'd0,
                                    ST_OK, 1'b0));
            walk_phase = AT_KIND;
         end
         KIND_TS: begin
            if (i < 6)
               acc_a = {acc_a[23:0], b};
            else
               acc_b = {acc_b[23:0], b};
            if (i >= 9) begin
               note_result(pack_result(RK_TS, KIND_TS, opt_len, acc_a, acc_b, ST_OK, 1'b0));
               walk_phase = AT_KIND;
            end
         end
         KIND_SACK: begin
            // eight bytes per block, left edge then right edge
            off = (i - 2) & 7;
            if (off < 4)
               acc_a = {acc_a[23:0], b};
            else
               acc_b = {acc_b[23:0], b};
            if (off == 7)
               note_result(pack_result(RK_SACK, KIND_SACK, opt_len, acc_a, acc_b,
                                       ST_OK, 1'b0));
            if (i + 1 >= opt_len)
               walk_phase = AT_KIND;
         end
         default: begin
            if (i + 1 >= opt_len)
               walk_phase = AT_KIND;
         end
      endcase
      body_pos = 8'(i + 1);
   endfunction

   function automatic void predict_beat(req_type beat);
      int n;
      beat_result_count = 0;
      n = beat.bytes_left;
      // zero reads as the last byte, big counts are clamped
      if (n == 0)
         n = 1;
      if (n > AREA_MAX)
         n = AREA_MAX;
      if (!area_halted) begin
         case (walk_phase)
            AT_KIND:   take_kind(beat.opt_byte, n);
            AT_LENGTH: take_length(beat.opt_byte, n);
            default:   take_body(beat.opt_byte);
         endcase
      end
      if (n == 1) begin
         if (!area_halted) begin
            if (walk_phase != AT_KIND)
               abort_area(opt_len, ST_TRUNC);  // area ran out mid-option
            else if (beat_result_count < 2)
               note_result(pack_result(RK_SUMMARY, 8'd0, 8'd0, 32'd0, 32'd0, ST_OK, 1'b1));
            else
               beat_results[1].done_res = 1'b1;  // no room for a summary
         end
         area_halted = 1'b0;
         walk_phase  = AT_KIND;
         body_pos    = 8'd0;
      end
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result beat: kind %0d code %0h", got.result_kind, got.option_code);
         mismatch_count++;
      end else begin
         want = expected_results.pop_front();
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("option_code", want.option_code, got.option_code);
         compare_field("length_byte", want.length_byte, got.length_byte);
         compare_field("value_a", want.value_a, got.value_a);
         compare_field("value_b", want.value_b, got.value_b);
         compare_field("status", want.status, got.status);
         compare_field("done_res", want.done_res, got.done_res);
      end
   endtask

   function automatic int idle_draw(bit burst);
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [7:0] rand_octet();
      return 8'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // called at a rising edge; returns at the edge where the beat is taken,
   // with valid left high so a back-to-back beat needs no second assignment
   task automatic send_beat(req_type beat, logic typed, logic [1:0] n_typed,
                            rsp_type r0, rsp_type r1);
      int gap;
      gap = idle_draw(req_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      predict_beat(beat);
      if (typed) begin
         if (n_typed > 0)
            expected_results.push_back(r0);
         if (n_typed > 1)
            expected_results.push_back(r1);
      end else begin
         for (int k = 0; k < beat_result_count; k++)
            expected_results.push_back(beat_results[k]);
      end
   endtask

   function automatic void add_row(logic [7:0] b, logic [5:0] left, logic typed,
                                   logic [1:0] n_typed, rsp_type r0, rsp_type r1);
      stim_row_type row;
      row.beat.opt_byte   = b;
      row.beat.bytes_left = left;
      row.typed           = typed;
      row.n_typed         = n_typed;
      row.r0              = r0;
      row.r1              = r1;
      stim_rows.push_back(row);
   endfunction

   // one option area of mostly well-formed options with random content;
   // options that overrun the area are cut, which gives truncation cases
   task automatic build_area();
      int budget;
      int len;
      int k;
      area_bytes.delete();
      budget = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      while (area_bytes.size() < budget) begin
         case ($urandom_range(0, 11))
            0: area_bytes.push_back(KIND_NOP);
            1: area_bytes.push_back(KIND_END);
            2: begin
               area_bytes.push_back(KIND_MSS);
               area_bytes.push_back(LEN_MSS);
               repeat (2) area_bytes.push_back(rand_octet());
            end
            3: begin
               area_bytes.push_back(KIND_WS);
               area_bytes.push_back(LEN_WS);
               area_bytes.push_back(rand_octet());
            end
            4: begin
               area_bytes.push_back(KIND_SACKP);
               area_bytes.push_back(LEN_SACKP);
            end
            5, 6: begin
               len = 2 + 8 * $urandom_range(1, 4);
               area_bytes.push_back(KIND_SACK);
               area_bytes.push_back(8'(len));
               repeat (len - 2) area_bytes.push_back(rand_octet());
            end
            7, 8: begin
               area_bytes.push_back(KIND_TS);
               area_bytes.push_back(LEN_TS);
               repeat (8) area_bytes.push_back(rand_octet());
            end
            9: begin
               // unknown kind, now and then with a length of 0, 1 or 2
               k = $urandom_range(6, 255);
               if (k == KIND_TS)
                  k = 7;
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 12);
               area_bytes.push_back(8'(k));
               area_bytes.push_back(8'(len));
               if (len > 2)
                  repeat (len - 2) area_bytes.push_back(rand_octet());
            end
            10: begin
               // known kind with a random length byte
               case ($urandom_range(0, 4))
                  0: area_bytes.push_back(KIND_MSS);
                  1: area_bytes.push_back(KIND_WS);
                  2: area_bytes.push_back(KIND_SACKP);
                  3: area_bytes.push_back(KIND_SACK);
                  default: area_bytes.push_back(KIND_TS);
               endcase
               area_bytes.push_back(rand_octet());
            end
            default: area_bytes.push_back(rand_octet());
         endcase
      end
      while (area_bytes.size() > budget)
         void'(area_bytes.pop_back());
   endtask

   // tags each byte with its count; the last byte gets 1 or 0, and now and then
   // a count is wrong or above the clamp
   task automatic send_area(bit noisy);
      int total;
      req_type beat;
      total = area_bytes.size();
      for (int idx = 0; idx < total; idx++) begin
         beat.opt_byte   = area_bytes[idx];
         beat.bytes_left = 6'(total - idx);
         if (total - idx == 1)
            beat.bytes_left = 6'($urandom_range(0, 1));
         else if (noisy || $urandom_range(0, 24) == 0)
            beat.bytes_left = 6'($urandom_range(0, 63));
         else if (total - idx == 40 && $urandom_range(0, 1) == 1)
            beat.bytes_left = 6'($urandom_range(41, 63));
         send_beat(beat, 1'b0, 2'd0, '0, '0);
         random_sent++;
      end
   endtask

   initial begin
      // end of list alone, then summary
      add_row(KIND_END, 6'd1, 1'b1, 2'd1,
              pack_result(RK_SUMMARY, 8'd0, 8'd0, 32'd0, 32'd0, ST_OK, 1'b1), '0);
      // clamped count, bad window scale length, rest of area skipped, zero count ends it
      add_row(KIND_WS, 6'd63, 1'b0, 2'd0, '0, '0);
      add_row(8'd5, 6'd62, 1'b1, 2'd1,
              pack_result(RK_WSCALE, KIND_WS, 8'd5, 32'd0, 32'd0, ST_BADLEN, 1'b1), '0);
      add_row(8'hAA, 6'd0, 1'b1, 2'd0, '0, '0);
      // nop, mss at its largest, sack permitted, window scale with no length byte
      add_row(KIND_NOP, 6'd8, 1'b0, 2'd0, '0, '0);
      add_row(KIND_MSS, 6'd7, 1'b0, 2'd0, '0, '0);
      add_row(LEN_MSS, 6'd6, 1'b0, 2'd0, '0, '0);
      add_row(8'hFF, 6'd5, 1'b0, 2'd0, '0, '0);
      add_row(8'hFF, 6'd4, 1'b0, 2'd0, '0, '0);
      add_row(KIND_SACKP, 6'd3, 1'b0, 2'd0, '0, '0);
      add_row(LEN_SACKP, 6'd2, 1'b0, 2'd0, '0, '0);
      add_row(KIND_WS, 6'd1, 1'b1, 2'd1,
              pack_result(RK_WSCALE, KIND_WS, 8'd0, 32'd0, 32'd0, ST_TRUNC, 1'b1), '0);
      // unknown of length 1 on the last byte: unknown then nop, nop closes the area
      add_row(8'd200, 6'd2, 1'b0, 2'd0, '0, '0);
      add_row(8'd1, 6'd1, 1'b1, 2'd2,
              pack_result(RK_UNKNOWN, 8'd200, 8'd1, 32'd0, 32'd0, ST_OK, 1'b0),
              pack_result(RK_NOP, KIND_NOP, 8'd0, 32'd0, 32'd0, ST_OK, 1'b1));
      // unknown option cut short by the end of the area
      add_row(8'hFF, 6'd40, 1'b0, 2'd0, '0, '0);
      add_row(8'd4, 6'd39, 1'b0, 2'd0, '0, '0);
      add_row(8'd0, 6'd1, 1'b1, 2'd1,
              pack_result(RK_UNKNOWN, 8'hFF, 8'd4, 32'd0, 32'd0, ST_TRUNC, 1'b1), '0);
      // one sack block filling the area
      add_row(KIND_SACK, 6'd10, 1'b0, 2'd0, '0, '0);
      add_row(8'd10, 6'd9, 1'b0, 2'd0, '0, '0);
      add_row(8'hFF, 6'd8, 1'b0, 2'd0, '0, '0);
      add_row(8'h00, 6'd7, 1'b0, 2'd0, '0, '0);
      add_row(8'h00, 6'd6, 1'b0, 2'd0, '0, '0);
      add_row(8'h00, 6'd5, 1'b0, 2'd0, '0, '0);
      add_row(8'hFF, 6'd4, 1'b0, 2'd0, '0, '0);
      add_row(8'h00, 6'd3, 1'b0, 2'd0, '0, '0);
      add_row(8'h00, 6'd2, 1'b0, 2'd0, '0, '0);
      add_row(8'h00, 6'd1, 1'b0, 2'd0, '0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r])
         send_beat(stim_rows[r].beat, stim_rows[r].typed, stim_rows[r].n_typed,
                   stim_rows[r].r0, stim_rows[r].r1);

      while (random_sent < RANDOM_BEATS) begin
         req_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) begin
            // noise: random bytes with random counts
            area_bytes.delete();
            repeat ($urandom_range(1, 12)) area_bytes.push_back(rand_octet());
            send_area(1'b1);
         end else begin
            build_area();
            send_area(1'b0);
         end
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------
   // result side: random back-pressure, each taken beat checked in order
   // ------------------------------------------------------------------
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_burst = !rsp_burst;
         stall = idle_draw(rsp_burst);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_result(rsp_data);
      end
   end

   // watchdog: too long without a beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule
